### sv/lc3b_pkg.sv
// ----------------------------------------------------------------------------
// lc3b_pkg
// Shared types, opcodes and helpers of the LC-3b instruction executor.
// ----------------------------------------------------------------------------
package lc3b_pkg;

	// action codes of an input word
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_SETPC = 2'd1;
	localparam logic [1:0] ACT_STEP  = 2'd2;

	// opcodes
	localparam logic [3:0] OP_BR   = 4'h0;
	localparam logic [3:0] OP_ADD  = 4'h1;
	localparam logic [3:0] OP_LDB  = 4'h2;
	localparam logic [3:0] OP_STB  = 4'h3;
	localparam logic [3:0] OP_JSR  = 4'h4;
	localparam logic [3:0] OP_AND  = 4'h5;
	localparam logic [3:0] OP_LDW  = 4'h6;
	localparam logic [3:0] OP_STW  = 4'h7;
	localparam logic [3:0] OP_XOR  = 4'h9;
	localparam logic [3:0] OP_JMP  = 4'hC;
	localparam logic [3:0] OP_SHF  = 4'hD;
	localparam logic [3:0] OP_LEA  = 4'hE;
	localparam logic [3:0] OP_TRAP = 4'hF;

	localparam logic [2:0] CC_RESET = 3'b010;
	localparam logic [2:0] R7       = 3'd7;

	// execute stage result handed to the sequencer
	typedef struct packed {
		logic        rw;        // writes a general register now
		logic [2:0]  dr;
		logic [15:0] v;
		logic        setc;
		logic [15:0] npc;       // next pc
		logic [15:0] ea;        // byte address of a memory access
		logic        mem_op;    // needs a data memory access
		logic        is_load;
		logic        is_byte;
		logic        is_store;
		logic        is_trap;
	} exe_res_t;

	function automatic logic [2:0] cc_of(input logic [15:0] v);
		logic [2:0] c;
		if (v[15])
			c = 3'b100;
		else if (v == 16'h0000)
			c = 3'b010;
		else
			c = 3'b001;
		return c;
	endfunction

endpackage

### sv/lc3b_mem.sv
// ----------------------------------------------------------------------------
// lc3b_mem
// Word memory, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lc3b_mem #(
	parameter int WORDS = 32768,
	parameter int AW    = 15
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [WORDS];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### sv/lc3b_rf.sv
// ----------------------------------------------------------------------------
// lc3b_rf
// Eight-entry register file, two registered read ports, reset valid bits.
// ----------------------------------------------------------------------------
module lc3b_rf (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        we,
	input  logic [2:0]  waddr,
	input  logic [15:0] wdata,
	input  logic [2:0]  raddr_a,
	input  logic [2:0]  raddr_b,
	output logic [15:0] rdata_a,
	output logic [15:0] rdata_b
);

	logic [15:0] regs [8];
	logic [7:0]  vld_q;
	logic [15:0] ra_q, rb_q;
	logic        va_q, vb_q;

	// valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			va_q  <= 1'b0;
			vb_q  <= 1'b0;
		end else begin
			if (we)
				vld_q[waddr] <= 1'b1;
			va_q <= vld_q[raddr_a];
			vb_q <= vld_q[raddr_b];
		end
	end

	// storage and read registers
	always_ff @(posedge clk) begin
		if (we)
			regs[waddr] <= wdata;
		ra_q <= regs[raddr_a];
		rb_q <= regs[raddr_b];
	end

	// entries never written read as zero
	assign rdata_a = va_q ? ra_q : 16'h0000;
	assign rdata_b = vb_q ? rb_q : 16'h0000;

endmodule

### sv/lc3b_alu.sv
// ----------------------------------------------------------------------------
// lc3b_alu
// Execute logic: operands, shifts, branch target and effective address.
// ----------------------------------------------------------------------------
module lc3b_alu
	import lc3b_pkg::*;
(
	input  logic [15:0] ir,
	input  logic [15:0] a,
	input  logic [15:0] rb,
	input  logic [15:0] pc_next,
	input  logic [2:0]  nzp,
	output exe_res_t    res
);

	logic [15:0] b, off5, off6, off9, off11;
	logic [3:0]  amt;

	assign off5  = {{11{ir[4]}}, ir[4:0]};
	assign off6  = {{10{ir[5]}}, ir[5:0]};
	assign off9  = {{7{ir[8]}}, ir[8:0]};
	assign off11 = {{5{ir[10]}}, ir[10:0]};
	assign b     = ir[5] ? off5 : rb;
	assign amt   = ir[3:0];

	// opcode decode
	always_comb begin
		res          = '0;
		res.dr       = ir[11:9];
		res.npc      = pc_next;
		res.ea       = a + off6;
		unique case (ir[15:12])
			OP_BR: begin
				if ((ir[11:9] & nzp) != 3'b000)
					res.npc = pc_next + {off9[14:0], 1'b0};
			end
			OP_ADD: begin
				res.v = a + b; res.rw = 1'b1; res.setc = 1'b1;
			end
			OP_AND: begin
				res.v = a & b; res.rw = 1'b1; res.setc = 1'b1;
			end
			OP_XOR: begin
				res.v = a ^ b; res.rw = 1'b1; res.setc = 1'b1;
			end
			OP_LDB: begin
				res.mem_op = 1'b1; res.is_load = 1'b1; res.is_byte = 1'b1;
			end
			OP_LDW: begin
				res.ea = a + {off6[14:0], 1'b0};
				res.mem_op = 1'b1; res.is_load = 1'b1;
			end
			OP_STB: begin
				res.mem_op = 1'b1; res.is_store = 1'b1; res.is_byte = 1'b1;
			end
			OP_STW: begin
				res.ea = a + {off6[14:0], 1'b0};
				res.mem_op = 1'b1; res.is_store = 1'b1;
			end
			OP_JSR: begin
				res.dr = R7; res.v = pc_next; res.rw = 1'b1;
				res.npc = ir[11] ? pc_next + {off11[14:0], 1'b0} : a;
			end
			OP_JMP: begin
				res.npc = a;
			end
			OP_SHF: begin
				if (!ir[4])
					res.v = a << amt;
				else if (ir[5])
					res.v = 16'($signed(a) >>> amt);
				else
					res.v = a >> amt;
				res.rw = 1'b1; res.setc = 1'b1;
			end
			OP_LEA: begin
				res.v = pc_next + {off9[14:0], 1'b0}; res.rw = 1'b1;
			end
			OP_TRAP: begin
				res.dr = R7; res.v = pc_next; res.rw = 1'b1;
				res.ea = {7'd0, ir[7:0], 1'b0};
				res.mem_op = 1'b1; res.is_trap = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

### sv/lc3b_instruction_executor_unit.sv
// ----------------------------------------------------------------------------
// lc3b_instruction_executor_unit
// LC-3b instruction-level core around one word memory and a register file.
//
//   channel | handshake           | payload
//   in      | in_valid / in_stall | action, word_address, word_data
//   out     | out_valid/out_stall | program_counter ... mem_write_data
//
// A memory write, a pc set, an unused action or a halted step passes
// through S_START and S_DONE; a step adds S_DEC and S_EXE, STW also S_ADR,
// and LDB, LDW, STB and TRAP also S_ADR and S_MEM, as they reach the word
// memory a second time after the fetch through its single read port.
// After reset all MEM_WORDS words of the memory are cleared, one word a
// cycle, while in_stall stays high. A result waits in the output register
// under out_stall; the next word is taken meanwhile and finishes when the
// output register is free.
// ----------------------------------------------------------------------------
module lc3b_instruction_executor_unit
	import lc3b_pkg::*;
#(
	parameter int MEM_WORDS = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [14:0] word_address,
	input  logic [15:0] word_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] program_counter,
	output logic        halted,
	output logic        reg_written,
	output logic [2:0]  reg_index,
	output logic [15:0] reg_value,
	output logic [2:0]  cond_codes,
	output logic [1:0]  mem_write_mask,
	output logic [14:0] mem_word_index,
	output logic [15:0] mem_write_data
);

	localparam int AW = $clog2(MEM_WORDS);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_DEC   = 3'd2;
	localparam logic [2:0] S_EXE   = 3'd3;
	localparam logic [2:0] S_ADR   = 3'd4;
	localparam logic [2:0] S_MEM   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	// word address modulo the memory size, eight compare-subtract steps
	function automatic logic [AW-1:0] word_idx(input logic [14:0] x);
		logic [14:0] r;
		r = x;
		for (int k = 7; k >= 0; k--) begin
			if ({8'd0, r} >= (23'(MEM_WORDS) << k))
				r = r - 15'(23'(MEM_WORDS) << k);
		end
		return AW'(r);
	endfunction

	logic [2:0]    state_q;
	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;
	logic [1:0]    act_q;
	logic [14:0]   waddr_q;
	logic [15:0]   wdata_q;
	logic [15:0]   pc_q, npc_q, ir_q, ea_q, sd_q;
	logic [2:0]    nzp_q;
	exe_res_t      res;
	logic [15:0]   rf_a, rf_b;

	// result fields being built
	logic          r_halt_q, r_rw_q;
	logic [2:0]    r_idx_q;
	logic [15:0]   r_val_q;
	logic [1:0]    r_mask_q;
	logic [14:0]   r_midx_q;
	logic [15:0]   r_mdata_q;

	// memory ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [15:0]   mem_wdata, mem_rdata;
	logic          rf_we;
	logic [2:0]    rf_waddr, rf_ra, rf_rb;
	logic [15:0]   rf_wdata;
	logic [15:0]   ld_val;
	logic          in_acc, out_free;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = clr_q || (state_q != S_IDLE);
	assign out_free = !out_valid || !out_stall;

	lc3b_mem #(.WORDS(MEM_WORDS), .AW(AW)) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	lc3b_rf u_rf (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (rf_we),
		.waddr  (rf_waddr),
		.wdata  (rf_wdata),
		.raddr_a(rf_ra),
		.raddr_b(rf_rb),
		.rdata_a(rf_a),
		.rdata_b(rf_b)
	);

	lc3b_alu u_alu (
		.ir     (ir_q),
		.a      (rf_a),
		.rb     (rf_b),
		.pc_next(npc_q),
		.nzp    (nzp_q),
		.res    (res)
	);

	// register file read addresses come straight from the fetched word
	assign rf_ra = mem_rdata[8:6];
	assign rf_rb = (mem_rdata[15:12] == OP_STB || mem_rdata[15:12] == OP_STW)
		? mem_rdata[11:9] : mem_rdata[2:0];

	// loaded value; for a byte load the byte lane is picked and sign extended
	always_comb begin
		if (ea_q[0])
			ld_val = {{8{mem_rdata[15]}}, mem_rdata[15:8]};
		else
			ld_val = {{8{mem_rdata[7]}}, mem_rdata[7:0]};
		if (!res.is_byte)
			ld_val = mem_rdata;
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = word_idx(waddr_q);
		mem_wdata = wdata_q;
		mem_raddr = word_idx(pc_q[15:1]);
		if (clr_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = 16'h0000;
		end else if (state_q == S_START && act_q == ACT_WRITE) begin
			mem_we = 1'b1;
		end else if (state_q == S_ADR) begin
			mem_raddr = word_idx(ea_q[15:1]);
			mem_waddr = word_idx(ea_q[15:1]);
			mem_wdata = sd_q;
			mem_we    = res.is_store && !res.is_byte;
		end else if (state_q == S_MEM && res.is_store) begin
			mem_waddr = word_idx(ea_q[15:1]);
			mem_we    = 1'b1;
			mem_wdata = ea_q[0] ? {sd_q[7:0], mem_rdata[7:0]}
				: {mem_rdata[15:8], sd_q[7:0]};
		end
	end

	// register file write control
	always_comb begin
		rf_we    = 1'b0;
		rf_waddr = res.dr;
		rf_wdata = res.v;
		if (state_q == S_EXE && res.rw) begin
			rf_we = 1'b1;
		end else if (state_q == S_MEM && res.is_load) begin
			rf_we    = 1'b1;
			rf_wdata = ld_val;
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(MEM_WORDS - 1))
				clr_q <= 1'b0;
		end
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pc_q      <= '0;
			nzp_q     <= CC_RESET;
			out_valid <= 1'b0;
		end else begin
			// a taken result leaves unless the next one is loaded now
			if (out_valid && !out_stall && state_q != S_DONE)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc)
						state_q <= S_START;
				end
				S_START: begin
					if (act_q == ACT_SETPC)
						pc_q <= wdata_q;
					if (act_q == ACT_STEP && pc_q != 16'h0000)
						state_q <= S_DEC;
					else
						state_q <= S_DONE;
				end
				S_DEC: begin
					state_q <= S_EXE;
				end
				S_EXE: begin
					if (res.setc)
						nzp_q <= cc_of(res.v);
					if (res.mem_op) begin
						state_q <= S_ADR;
					end else begin
						pc_q    <= res.npc;
						state_q <= S_DONE;
					end
				end
				S_ADR: begin
					state_q <= (res.is_store && !res.is_byte) ? S_DONE : S_MEM;
					if (res.is_store && !res.is_byte)
						pc_q <= npc_q;
				end
				S_MEM: begin
					pc_q    <= res.is_trap ? mem_rdata : npc_q;
					if (res.is_load)
						nzp_q <= cc_of(ld_val);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload and result fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q     <= action;
			waddr_q   <= word_address;
			wdata_q   <= word_data;
			r_halt_q  <= 1'b0;
			r_rw_q    <= 1'b0;
			r_idx_q   <= '0;
			r_val_q   <= '0;
			r_mask_q  <= '0;
			r_midx_q  <= '0;
			r_mdata_q <= '0;
		end
		if (state_q == S_START) begin
			r_halt_q <= (act_q == ACT_STEP) && (pc_q == 16'h0000);
			npc_q    <= pc_q + 16'd2;
		end
		if (state_q == S_DEC)
			ir_q <= mem_rdata;
		if (state_q == S_EXE) begin
			ea_q <= res.ea;
			sd_q <= res.is_byte ? {8'h00, rf_b[7:0]} : rf_b;
			if (res.rw) begin
				r_rw_q  <= 1'b1;
				r_idx_q <= res.dr;
				r_val_q <= res.v;
			end
		end
		if (state_q == S_ADR && res.is_store) begin
			r_midx_q  <= 15'(word_idx(ea_q[15:1]));
			r_mask_q  <= !res.is_byte ? 2'b11 : (ea_q[0] ? 2'b10 : 2'b01);
			r_mdata_q <= !res.is_byte ? sd_q
				: (ea_q[0] ? {sd_q[7:0], 8'h00} : sd_q);
		end
		if (state_q == S_MEM && res.is_load) begin
			r_rw_q  <= 1'b1;
			r_idx_q <= res.dr;
			r_val_q <= ld_val;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			program_counter <= pc_q;
			halted          <= r_halt_q;
			reg_written     <= r_rw_q;
			reg_index       <= r_idx_q;
			reg_value       <= r_val_q;
			cond_codes      <= nzp_q;
			mem_write_mask  <= r_mask_q;
			mem_word_index  <= r_midx_q;
			mem_write_data  <= r_mdata_q;
		end
	end

	// no item is taken during the clearing pass
	a_clr_stall: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> in_stall) else $error("item accepted while clearing");

	// condition codes always hold exactly one flag
	a_cc_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(cond_codes)) else $error("bad condition codes");

	// a halted step neither writes a register nor stores
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && halted) |-> (!reg_written && mem_write_mask == 2'b00))
		else $error("halted step changed state");

	// a step never both stores and writes a register
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(reg_written && mem_write_mask != 2'b00))
		else $error("store and register write together");

endmodule
